>>> rtl/core/ovpa_pkg.sv
// Shared constants, codes and the plane ordering key for the overlay plane allocator.
// Used by ovpa_keycmp and overlay_plane_allocator_core; no dependencies.
`timescale 1ns / 1ps

package ovpa_pkg;

    // default table dimensions
    localparam int NUM_PLANES_DEF = 16;
    localparam int NUM_PIPES_DEF  = 4;
    localparam int NUM_FMTS_DEF   = 8;

    // grant list per pipe
    localparam int MAX_GRANT = 16;
    localparam int GRANT_IW  = 4;   // index into one grant list
    localparam int GRANT_CW  = 5;   // grant count, 0..MAX_GRANT

    localparam int Z_W  = 64;
    localparam int ID_W = 32;

    // command codes
    localparam logic [2:0] MODE_LOAD_PLANE = 3'd0;
    localparam logic [2:0] MODE_LOAD_FMT   = 3'd1;
    localparam logic [2:0] MODE_RESERVE    = 3'd2;
    localparam logic [2:0] MODE_RELEASE    = 3'd3;
    localparam logic [2:0] MODE_LIST       = 3'd4;

    // result status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_UNAVAIL = 1'b1;

    // ordering key: z first, then id
    typedef struct packed {
        logic [Z_W-1:0]  z;
        logic [ID_W-1:0] id;
    } t_key;

endpackage

>>> rtl/core/ovpa_keycmp.sv
// Shared key comparator: (z, id) less-than, also used for the z floor check.
// Depends on ovpa_pkg.
`timescale 1ns / 1ps

module ovpa_keycmp import ovpa_pkg::*; (
    input  t_key i_a,
    input  t_key i_b,
    output logic o_lt
);

    // z occupies the upper bits; the compare orders by z first, then by id
    assign o_lt = (i_a.z < i_b.z) || ((i_a.z == i_b.z) && (i_a.id < i_b.id));

endmodule

>>> rtl/core/overlay_plane_allocator_core.sv
// Overlay plane allocator: plane table, format rows, grant lists and the scan sequencer.
// Loads, release or list of an empty list and bad requests give their single beat from S_EMIT1.
// Reserve: drops the L old grants, qualifies every plane, then scans all planes for each granted
// plane on the single shared key comparator. List: read, index and emit for each listed plane.
// One item at a time; the input stalls until the last result beat is loaded.
// Synchronous active-low reset clears loaded, taken and format valid bits and all grant lengths.
`timescale 1ns / 1ps

module overlay_plane_allocator_core import ovpa_pkg::*; #(
    parameter int NUM_PLANES        = NUM_PLANES_DEF,
    parameter int NUM_PIPES         = NUM_PIPES_DEF,
    parameter int FORMATS_PER_PLANE = NUM_FMTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [1:0]  i_pipe,
    input  logic [3:0]  i_plane_slot,
    input  logic [31:0] i_plane_ident,
    input  logic        i_is_overlay,
    input  logic        i_has_zpos,
    input  logic [3:0]  i_pipe_mask,
    input  logic [2:0]  i_format_slot,
    input  logic [31:0] i_format_code,
    input  logic [4:0]  i_want_count,
    input  logic [63:0] i_zpos_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_granted_plane,
    output logic        o_has_plane,
    output logic        o_status,
    output logic        o_last
);

    localparam int SW     = $clog2(NUM_PLANES);
    localparam int PIW    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int FW     = (FORMATS_PER_PLANE > 1) ? $clog2(FORMATS_PER_PLANE) : 1;
    localparam int GDEPTH = NUM_PIPES * MAX_GRANT;
    localparam int GAW    = PIW + GRANT_IW;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DROP_RD   = 4'd1;
    localparam logic [3:0] S_DROP_WR   = 4'd2;
    localparam logic [3:0] S_QUAL_RD   = 4'd3;
    localparam logic [3:0] S_QUAL_EV   = 4'd4;
    localparam logic [3:0] S_SEL_SCAN  = 4'd5;
    localparam logic [3:0] S_SEL_EMIT  = 4'd6;
    localparam logic [3:0] S_LIST_RD   = 4'd7;
    localparam logic [3:0] S_LIST_IDX  = 4'd8;
    localparam logic [3:0] S_LIST_EMIT = 4'd9;
    localparam logic [3:0] S_EMIT1     = 4'd10;

    // plane table
    logic [NUM_PLANES-1:0] r_loaded;
    logic [NUM_PLANES-1:0] r_taken;
    logic [ID_W-1:0]       r_ident [NUM_PLANES];
    logic                  r_ovl   [NUM_PLANES];
    logic                  r_hz    [NUM_PLANES];
    logic [Z_W-1:0]        r_z     [NUM_PLANES];
    logic [3:0]            r_pipes [NUM_PLANES];

    // format rows and valid bits
    logic [31:0]                  fmt_mem [NUM_PLANES][FORMATS_PER_PLANE];
    logic [31:0]                  r_fmt_row [FORMATS_PER_PLANE];
    logic [FORMATS_PER_PLANE-1:0] r_fvalid [NUM_PLANES];

    // grant lists
    logic [SW-1:0]       gl_mem [GDEPTH];
    logic [SW-1:0]       r_gl_q;
    logic [GRANT_CW-1:0] r_len [NUM_PIPES];

    // sequencer state
    logic [3:0]            r_state, n_state;
    logic [2:0]            r_mode, n_mode;
    logic [PIW-1:0]        r_pipe, n_pipe;
    logic [31:0]           r_fmt, n_fmt;
    logic [4:0]            r_want, n_want;
    logic [Z_W-1:0]        r_floor, n_floor;
    logic                  r_status, n_status;
    logic [GRANT_CW-1:0]   r_k, n_k;
    logic [SW-1:0]         r_idx, n_idx;
    logic [SW:0]           r_n, n_n;
    logic [SW-1:0]         r_best, n_best;
    logic                  r_best_vld, n_best_vld;
    t_key                  r_best_key, n_best_key;
    logic [NUM_PLANES-1:0] r_cand, r_pick;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_id;
    logic        r_out_has, r_out_st, r_out_last;

    // strobes
    logic wr_plane, wr_fmt, drop_clr, len_clr, cand_we, pick_we, mark, clr_pick, out_load;
    logic [31:0] out_id;
    logic        out_has, out_st, out_last;

    // input decode
    logic [PIW+1:0] pipe_ext;
    logic [PIW-1:0] pipe_in;
    logic           pipe_ok_in;
    logic [SW+3:0]  slot_ext;
    logic [SW-1:0]  slot_in;
    logic           slot_ok;
    logic [FW+2:0]  fs_ext;
    logic [FW-1:0]  fs_in;
    logic           fs_ok;
    logic [GRANT_CW-1:0] in_len, cur_len;

    assign pipe_ext   = (PIW+2)'(i_pipe);
    assign pipe_in    = pipe_ext[PIW-1:0];
    assign pipe_ok_in = int'(i_pipe) < NUM_PIPES;
    assign slot_ext   = (SW+4)'(i_plane_slot);
    assign slot_in    = slot_ext[SW-1:0];
    assign slot_ok    = int'(i_plane_slot) < NUM_PLANES;
    assign fs_ext     = (FW+3)'(i_format_slot);
    assign fs_in      = fs_ext[FW-1:0];
    assign fs_ok      = int'(i_format_slot) < FORMATS_PER_PLANE;
    assign in_len     = r_len[pipe_in];
    assign cur_len    = r_len[r_pipe];

    logic [GAW-1:0] gl_addr;
    assign gl_addr = {r_pipe, r_k[GRANT_IW-1:0]};

    // shared comparator operands
    t_key cur_key, cmp_a, cmp_b;
    logic key_lt;

    assign cur_key = '{z: r_z[r_idx], id: r_ident[r_idx]};

    always_comb begin
        if (r_state == S_QUAL_EV) begin
            cmp_a = '{z: r_z[r_idx], id: '0};
            cmp_b = '{z: r_floor, id: '0};
        end else begin
            cmp_a = cur_key;
            cmp_b = r_best_key;
        end
    end

    ovpa_keycmp u_keycmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (key_lt)
    );

    // qualification of the slot under the scan index
    logic [3:0] pipes_sh;
    logic       sup, hit, cand;

    always_comb begin
        pipes_sh = r_pipes[r_idx] >> r_pipe;
        sup = 1'b0;
        for (int f = 0; f < FORMATS_PER_PLANE; f++) begin
            sup = sup | (r_fvalid[r_idx][f] & (r_fmt_row[f] == r_fmt));
        end
        hit = 1'b0;
        for (int t = 0; t < NUM_PLANES; t++) begin
            hit = hit | (r_taken[t] & r_loaded[t] & (r_ident[t] == r_ident[r_idx]));
        end
        cand = r_loaded[r_idx] & r_ovl[r_idx] & pipes_sh[0] & r_hz[r_idx] & ~key_lt
             & sup & ~hit;
    end

    logic out_free;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_pipe     = r_pipe;
        n_fmt      = r_fmt;
        n_want     = r_want;
        n_floor    = r_floor;
        n_status   = r_status;
        n_k        = r_k;
        n_idx      = r_idx;
        n_n        = r_n;
        n_best     = r_best;
        n_best_vld = r_best_vld;
        n_best_key = r_best_key;
        wr_plane = 1'b0;
        wr_fmt   = 1'b0;
        drop_clr = 1'b0;
        len_clr  = 1'b0;
        cand_we  = 1'b0;
        pick_we  = 1'b0;
        mark     = 1'b0;
        clr_pick = 1'b0;
        out_load = 1'b0;
        out_id   = '0;
        out_has  = 1'b0;
        out_st   = ST_OK;
        out_last = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = i_mode;
                    n_pipe   = pipe_in;
                    n_fmt    = i_format_code;
                    n_want   = i_want_count;
                    n_floor  = i_zpos_value;
                    n_k      = '0;
                    n_idx    = '0;
                    n_n      = '0;
                    n_status = ST_OK;
                    n_state  = S_EMIT1;
                    unique case (i_mode)
                        MODE_LOAD_PLANE: wr_plane = slot_ok;
                        MODE_LOAD_FMT:   wr_fmt   = slot_ok && fs_ok;
                        MODE_RESERVE: begin
                            if (i_want_count == '0) begin
                                n_status = ST_OK;
                            end else if (!pipe_ok_in) begin
                                n_status = ST_UNAVAIL;
                            end else begin
                                clr_pick = 1'b1;
                                n_state  = (in_len != '0) ? S_DROP_RD : S_QUAL_RD;
                            end
                        end
                        MODE_RELEASE: begin
                            if (pipe_ok_in && in_len != '0) begin
                                n_state = S_DROP_RD;
                            end
                        end
                        MODE_LIST: begin
                            if (pipe_ok_in && in_len != '0) begin
                                n_state = S_LIST_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DROP_RD: n_state = S_DROP_WR;
            S_DROP_WR: begin
                drop_clr = 1'b1;
                n_k      = r_k + GRANT_CW'(1);
                if (n_k == cur_len) begin
                    len_clr = 1'b1;
                    n_idx   = '0;
                    n_n     = '0;
                    n_state = (r_mode == MODE_RESERVE) ? S_QUAL_RD : S_EMIT1;
                end else begin
                    n_state = S_DROP_RD;
                end
            end
            S_QUAL_RD: n_state = S_QUAL_EV;
            S_QUAL_EV: begin
                cand_we = 1'b1;
                n_n     = r_n + (SW+1)'(cand);
                if (r_idx == SW'(NUM_PLANES - 1)) begin
                    if (r_want > GRANT_CW'(MAX_GRANT) || int'(n_n) < int'(r_want)) begin
                        n_status = ST_UNAVAIL;
                        n_state  = S_EMIT1;
                    end else begin
                        n_idx      = '0;
                        n_k        = '0;
                        n_best_vld = 1'b0;
                        n_state    = S_SEL_SCAN;
                    end
                end else begin
                    n_idx   = r_idx + SW'(1);
                    n_state = S_QUAL_RD;
                end
            end
            S_SEL_SCAN: begin
                if (r_cand[r_idx] && (!r_best_vld || key_lt)) begin
                    n_best     = r_idx;
                    n_best_key = cur_key;
                    n_best_vld = 1'b1;
                end
                if (r_idx == SW'(NUM_PLANES - 1)) begin
                    n_state = S_SEL_EMIT;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            S_SEL_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_id   = r_best_key.id;
                    out_has  = 1'b1;
                    out_last = ((r_k + GRANT_CW'(1)) == r_want);
                    pick_we  = 1'b1;
                    n_k      = r_k + GRANT_CW'(1);
                    if (out_last) begin
                        mark    = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx      = '0;
                        n_best_vld = 1'b0;
                        n_state    = S_SEL_SCAN;
                    end
                end
            end
            S_LIST_RD: n_state = S_LIST_IDX;
            S_LIST_IDX: begin
                n_idx   = r_gl_q;
                n_state = S_LIST_EMIT;
            end
            S_LIST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_id   = r_loaded[r_idx] ? r_ident[r_idx] : '0;
                    out_has  = 1'b1;
                    out_last = ((r_k + GRANT_CW'(1)) == cur_len);
                    n_k      = r_k + GRANT_CW'(1);
                    n_state  = out_last ? S_IDLE : S_LIST_RD;
                end
            end
            S_EMIT1: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_st   = r_status;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loaded    <= '0;
            r_taken     <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < NUM_PLANES; s++) begin
                r_fvalid[s] <= '0;
            end
            for (int p = 0; p < NUM_PIPES; p++) begin
                r_len[p] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (wr_plane) begin
                r_loaded[slot_in] <= 1'b1;
                r_fvalid[slot_in] <= '0;
            end
            if (wr_fmt) begin
                r_fvalid[slot_in][fs_in] <= 1'b1;
            end
            if (drop_clr) begin
                r_taken[r_gl_q] <= 1'b0;
            end
            if (mark) begin
                r_taken <= r_taken | r_pick | (NUM_PLANES'(1) << r_best);
            end
            if (len_clr) begin
                r_len[r_pipe] <= '0;
            end else if (mark) begin
                r_len[r_pipe] <= r_want;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers and memories
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_pipe     <= n_pipe;
        r_fmt      <= n_fmt;
        r_want     <= n_want;
        r_floor    <= n_floor;
        r_status   <= n_status;
        r_k        <= n_k;
        r_idx      <= n_idx;
        r_n        <= n_n;
        r_best     <= n_best;
        r_best_vld <= n_best_vld;
        r_best_key <= n_best_key;
        if (wr_plane) begin
            r_ident[slot_in] <= i_plane_ident;
            r_ovl[slot_in]   <= i_is_overlay;
            r_hz[slot_in]    <= i_has_zpos;
            r_z[slot_in]     <= i_zpos_value;
            r_pipes[slot_in] <= i_pipe_mask;
        end
        if (wr_fmt) begin
            fmt_mem[slot_in][fs_in] <= i_format_code;
        end
        r_fmt_row <= fmt_mem[r_idx];
        r_gl_q    <= gl_mem[gl_addr];
        if (cand_we) begin
            r_cand[r_idx] <= cand;
        end
        if (clr_pick) begin
            r_pick <= '0;
        end
        if (pick_we) begin
            gl_mem[gl_addr] <= r_best;
            r_cand[r_best]  <= 1'b0;
            r_pick[r_best]  <= 1'b1;
        end
        if (out_load) begin
            r_out_id   <= out_id;
            r_out_has  <= out_has;
            r_out_st   <= out_st;
            r_out_last <= out_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted_plane = r_out_id;
    assign o_has_plane     = r_out_has;
    assign o_status        = r_out_st;
    assign o_last          = r_out_last;

    // checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    a_pick_exists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL_EMIT) |-> r_best_vld)
        else $error("selection pass found no candidate");

    a_no_plane_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_plane) |-> (o_granted_plane == '0))
        else $error("plane id on an empty result beat");

    a_unavail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_UNAVAIL) |-> (o_last && !o_has_plane))
        else $error("unavailable beat carries a plane or is not last");

endmodule
